[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RROL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RROL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rrol_pkg.sv]
// ----------------------------------------------------------------------------
// Record ring package
// Field widths, command codes, record and result types, sequencer states.
// ----------------------------------------------------------------------------
package rrol_pkg;

    localparam int HANDLE_W = 32;
    localparam int LEN_W    = 16;
    localparam int OFS_W    = 20;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_FIND = 1'b1;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    length;
    } rec_t;

    typedef struct packed {
        logic             command;
        rec_t             rec;
        logic [OFS_W-1:0] seek_offset;
    } cmd_t;

    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] hit_handle;
        logic [LEN_W-1:0]    hit_length;
        logic [LEN_W-1:0]    byte_in_record;
        logic                evicted_valid;
        logic [HANDLE_W-1:0] evicted_handle;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_FIND,
        ST_DONE
    } state_t;

endpackage

[rtl/rrol_if.sv]
// ----------------------------------------------------------------------------
// Record ring channels
// Valid/ready command and result channels.
// ----------------------------------------------------------------------------
interface rrol_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [rrol_pkg::HANDLE_W-1:0] record_handle;
    logic [rrol_pkg::LEN_W-1:0]    record_length;
    logic [rrol_pkg::OFS_W-1:0]    seek_offset;

    modport source (output valid, command, record_handle, record_length, seek_offset,
                    input ready);
    modport sink   (input valid, command, record_handle, record_length, seek_offset,
                    output ready);
endinterface

interface rrol_res_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [rrol_pkg::HANDLE_W-1:0] hit_handle;
    logic [rrol_pkg::LEN_W-1:0]    hit_length;
    logic [rrol_pkg::LEN_W-1:0]    byte_in_record;
    logic                          evicted_valid;
    logic [rrol_pkg::HANDLE_W-1:0] evicted_handle;

    modport source (output valid, found, hit_handle, hit_length, byte_in_record,
                    evicted_valid, evicted_handle, input ready);
    modport sink   (input valid, found, hit_handle, hit_length, byte_in_record,
                    evicted_valid, evicted_handle, output ready);
endinterface

[rtl/rrol_store.sv]
// ----------------------------------------------------------------------------
// Record store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rrol_store #(
    parameter int DEPTH = 16,
    parameter int PTR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [PTR_W-1:0]  wr_addr,
    input  rrol_pkg::rec_t    wr_rec,
    input  logic              rd_en,
    input  logic [PTR_W-1:0]  rd_addr,
    output rrol_pkg::rec_t    rd_rec
);
    import rrol_pkg::*;

    rec_t mem [DEPTH];
    rec_t rd_rec_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_rec;
        end
        if (rd_en)
        begin
            rd_rec_reg <= mem[rd_addr];
        end
    end

    assign rd_rec = rd_rec_reg;

endmodule

[rtl/rrol_seq.sv]
// ----------------------------------------------------------------------------
// Record ring sequencer
// Ring pointers plus one shared compare/subtract unit that walks the records.
// ----------------------------------------------------------------------------
module rrol_seq #(
    parameter int DEPTH = 16,
    parameter int PTR_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  rrol_pkg::cmd_t    cmd_in,
    output logic              wr_en,
    output logic [PTR_W-1:0]  wr_addr,
    output rrol_pkg::rec_t    wr_rec,
    output logic              rd_en,
    output logic [PTR_W-1:0]  rd_addr,
    input  rrol_pkg::rec_t    rd_rec,
    input  logic              res_ready,
    output logic              res_valid,
    output rrol_pkg::res_t    res_out
);
    import rrol_pkg::*;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic              full_reg, full_next;
    logic [PTR_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dvld_reg, dvld_next;
    logic [OFS_W-1:0]  rem_reg, rem_next;
    rec_t              rec_reg, rec_next;
    res_t              res_reg, res_next;

    // shared unit: remaining offset against the length just read
    logic [OFS_W-1:0]  len_ext;
    logic              hit;
    logic [OFS_W-1:0]  rem_sub;
    logic              accept;
    logic              walk_done;
    logic [CNT_W-1:0]  stored;

    assign len_ext   = {{(OFS_W - LEN_W){1'b0}}, rd_rec.length};
    assign hit       = dvld_reg && (rem_reg < len_ext);
    assign rem_sub   = rem_reg - len_ext;
    assign accept    = cmd_valid && cmd_ready;
    assign walk_done = (issue_reg == count_reg);

    always_comb
    begin
        if (full_reg)
        begin
            stored = CNT_W'(DEPTH);
        end
        else if (wp_reg >= rp_reg)
        begin
            stored = CNT_W'(wp_reg) - CNT_W'(rp_reg);
        end
        else
        begin
            stored = CNT_W'(DEPTH) - CNT_W'(rp_reg) + CNT_W'(wp_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cmd_in.command == CMD_FIND) ? ST_FIND : ST_ADD_RD;
                end
            end
            ST_ADD_RD: state_next = ST_ADD_WR;
            ST_ADD_WR: state_next = ST_DONE;
            ST_FIND:
            begin
                if (hit || walk_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = rp_reg;
        wr_en     = 1'b0;
        wr_addr   = wp_reg;
        wr_rec    = rec_reg;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:   cmd_ready = 1'b1;
            ST_ADD_RD: rd_en = 1'b1;
            ST_ADD_WR: wr_en = 1'b1;
            ST_FIND:
            begin
                rd_en   = !walk_done;
                rd_addr = pos_reg;
            end
            ST_DONE:   res_valid = 1'b1;
            default:   cmd_ready = 1'b0;
        endcase
    end

    // datapath
    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        full_next  = full_reg;
        pos_next   = pos_reg;
        issue_next = issue_reg;
        count_next = count_reg;
        dvld_next  = 1'b0;
        rem_next   = rem_reg;
        rec_next   = rec_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rec_next   = cmd_in.rec;
                    rem_next   = cmd_in.seek_offset;
                    pos_next   = rp_reg;
                    issue_next = '0;
                    count_next = stored;
                end
            end
            ST_ADD_WR:
            begin
                res_next = '0;
                if (full_reg)
                begin
                    res_next.evicted_valid  = 1'b1;
                    res_next.evicted_handle = rd_rec.handle;
                    rp_next = next_slot(rp_reg);
                end
                wp_next   = next_slot(wp_reg);
                full_next = (next_slot(wp_reg) == rp_next);
            end
            ST_FIND:
            begin
                if (!walk_done)
                begin
                    pos_next   = next_slot(pos_reg);
                    issue_next = issue_reg + 1'b1;
                    dvld_next  = 1'b1;
                end
                if (dvld_reg && !hit)
                begin
                    rem_next = rem_sub;
                end
                if (hit || walk_done)
                begin
                    res_next = '0;
                    if (hit)
                    begin
                        res_next.found          = 1'b1;
                        res_next.hit_handle     = rd_rec.handle;
                        res_next.hit_length     = rd_rec.length;
                        res_next.byte_in_record = rem_reg[LEN_W-1:0];
                    end
                end
            end
            default:
            begin
                dvld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            full_reg  <= 1'b0;
            issue_reg <= '0;
            count_reg <= '0;
            dvld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            full_reg  <= full_next;
            issue_reg <= issue_next;
            count_reg <= count_next;
            dvld_reg  <= dvld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        rem_reg <= rem_next;
        rec_reg <= rec_next;
        res_reg <= res_next;
    end

    assign res_out = res_reg;

endmodule

[rtl/record_ring_with_offset_lookup_top.sv]
// ----------------------------------------------------------------------------
// Record ring with offset lookup
// Overwriting ring of DEPTH (handle, length) records with an offset search.
// ----------------------------------------------------------------------------
//  channel  modport  transaction
//  cmd      sink     add record / find record holding seek_offset
//  res      source   one result per command
//
//  Add: accept, read oldest slot, write, hand the result over.
//  Find: one stored record per cycle through the shared compare/subtract unit
//  (records oldest first, read one per cycle from the store), stops at the hit
//  or after the newest stored record.
//  Reset clears pointers, full flag and control; record store is not cleared.
//  A stalled result sits in the output register; the next command is taken
//  meanwhile, and its result waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module record_ring_with_offset_lookup_top #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    rrol_cmd_if.sink    cmd,
    rrol_res_if.source  res
);
    import rrol_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    cmd_t              cmd_data;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    rec_t              wr_rec;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    rec_t              rd_rec;
    logic              seq_res_valid;
    logic              seq_res_ready;
    res_t              seq_res;

    // output register
    logic              out_valid_reg;
    res_t              out_data_reg;

    assign cmd_data.command     = cmd.command;
    assign cmd_data.rec.handle  = cmd.record_handle;
    assign cmd_data.rec.length  = cmd.record_length;
    assign cmd_data.seek_offset = cmd.seek_offset;

    rrol_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_rec  (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_rec  (rd_rec)
    );

    rrol_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .cmd_in    (cmd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_rec    (wr_rec),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_rec    (rd_rec),
        .res_ready (seq_res_ready),
        .res_valid (seq_res_valid),
        .res_out   (seq_res)
    );

    // register is free when empty or being drained this cycle
    assign seq_res_ready = !out_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (seq_res_ready)
        begin
            out_valid_reg <= seq_res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_res_ready && seq_res_valid)
        begin
            out_data_reg <= seq_res;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.found          = out_data_reg.found;
    assign res.hit_handle     = out_data_reg.hit_handle;
    assign res.hit_length     = out_data_reg.hit_length;
    assign res.byte_in_record = out_data_reg.byte_in_record;
    assign res.evicted_valid  = out_data_reg.evicted_valid;
    assign res.evicted_handle = out_data_reg.evicted_handle;

endmodule

[rtl/rrol_checker.sv]
// ----------------------------------------------------------------------------
// Record ring checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrol_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic                          cmd_ready,
    input  logic                          res_valid,
    input  logic                          res_ready,
    input  logic                          found,
    input  logic [rrol_pkg::HANDLE_W-1:0] hit_handle,
    input  logic [rrol_pkg::LEN_W-1:0]    hit_length,
    input  logic [rrol_pkg::LEN_W-1:0]    byte_in_record,
    input  logic                          evicted_valid,
    input  logic [rrol_pkg::HANDLE_W-1:0] evicted_handle
);
    import rrol_pkg::*;

    // one command in the sequencer at a time: busy right after a transaction
    `RROL_ASSERT_NXT(a_busy_after_cmd, cmd_valid && cmd_ready, !cmd_ready, "ready after cmd")
    `RROL_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped")
    `RROL_ASSERT_IMP(a_miss_zero, res_valid && !found, hit_handle == '0 && hit_length == '0 && byte_in_record == '0, "miss fields nonzero")
    `RROL_ASSERT_IMP(a_hit_inside, res_valid && found, byte_in_record < hit_length && !evicted_valid, "bad hit")
    `RROL_ASSERT_IMP(a_evict_zero, res_valid && !evicted_valid, evicted_handle == '0, "evict handle nonzero")

endmodule

bind record_ring_with_offset_lookup_top rrol_checker u_rrol_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .found          (res.found),
    .hit_handle     (res.hit_handle),
    .hit_length     (res.hit_length),
    .byte_in_record (res.byte_in_record),
    .evicted_valid  (res.evicted_valid),
    .evicted_handle (res.evicted_handle)
);
